// ===== rtl/dq_pkg.sv =====
// shared constants, types and ring pointer helpers for the double-ended queue
package dq_pkg;

	localparam int DEPTH    = 16;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
		logic dump_start;
		logic dump_step;
		logic reject_full;
		logic reject_empty;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic single;
		logic dump_last;
	} sts_t;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, pos} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] pos);
		logic [IDX_W-1:0] r;
		if (pos == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = pos - 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/dq_ram.sv =====
// generic single write port ram with registered read
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dq_ctrl.sv =====
// request decode and dump sequencing state machine
module dq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dq_pkg::KIND_W-1:0] kind,
	input  dq_pkg::sts_t              sts,
	output dq_pkg::cmd_t              cmd,
	output logic                      busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind)
						dq_pkg::KIND_PUSH_FRONT: begin
							if (sts.full) cmd.reject_full = 1'b1;
							else cmd.push_front = 1'b1;
						end
						dq_pkg::KIND_PUSH_REAR: begin
							if (sts.full) cmd.reject_full = 1'b1;
							else cmd.push_rear = 1'b1;
						end
						dq_pkg::KIND_POP_FRONT: begin
							if (sts.empty) cmd.reject_empty = 1'b1;
							else cmd.pop_front = 1'b1;
						end
						dq_pkg::KIND_POP_REAR: begin
							if (sts.empty) cmd.reject_empty = 1'b1;
							else cmd.pop_rear = 1'b1;
						end
						dq_pkg::KIND_DUMP: begin
							if (sts.empty) begin
								cmd.reject_empty = 1'b1;
							end else begin
								cmd.dump_start = 1'b1;
								if (!sts.single) state_d = ST_DUMP;
							end
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			ST_DUMP: begin
				cmd.dump_step = 1'b1;
				if (sts.dump_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/dq_dpath.sv =====
// ring store, front pointer, fill count and result registers
module dq_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dq_pkg::cmd_t                       cmd,
	input  logic signed [dq_pkg::WORD_W-1:0]   value_in,
	output dq_pkg::sts_t                       sts,
	output logic                               valid,
	output logic signed [dq_pkg::WORD_W-1:0]   value_out,
	output logic [dq_pkg::STATUS_W-1:0]        status,
	output logic                               last
);

	logic [dq_pkg::IDX_W-1:0]    front_q;
	logic [dq_pkg::CNT_W-1:0]    count_q;
	logic [dq_pkg::IDX_W-1:0]    idx_q;
	logic                        valid_q;
	logic [dq_pkg::STATUS_W-1:0] status_q;
	logic                        last_q;
	logic                        from_ram_q;

	logic                        we;
	logic [dq_pkg::IDX_W-1:0]    waddr;
	logic                        re;
	logic [dq_pkg::IDX_W-1:0]    raddr;
	logic [dq_pkg::WORD_W-1:0]   rdata;
	logic [dq_pkg::IDX_W-1:0]    front_dec;
	logic [dq_pkg::CNT_W-1:0]    count_m1;

	assign front_dec = dq_pkg::ring_dec(front_q);
	assign count_m1  = count_q - 1'b1;

	assign sts.full      = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.single    = (count_q == dq_pkg::CNT_W'(1));
	assign sts.dump_last = (dq_pkg::CNT_W'(idx_q) == count_m1);

	always_comb begin
		we = cmd.push_front | cmd.push_rear;
		if (cmd.push_front) waddr = front_dec;
		else waddr = dq_pkg::ring_add(front_q, count_q);
		re = cmd.pop_front | cmd.pop_rear | cmd.dump_start | cmd.dump_step;
		if (cmd.pop_rear) raddr = dq_pkg::ring_add(front_q, count_m1);
		else if (cmd.dump_step) raddr = dq_pkg::ring_add(front_q, dq_pkg::CNT_W'(idx_q));
		else raddr = front_q;
	end

	dq_ram #(
		.WIDTH(dq_pkg::WORD_W),
		.DEPTH(dq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value_in),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			valid_q    <= 1'b0;
			status_q   <= dq_pkg::STATUS_OK;
			last_q     <= 1'b0;
			from_ram_q <= 1'b0;
		end else begin
			if (cmd.push_front) front_q <= front_dec;
			else if (cmd.pop_front) front_q <= dq_pkg::ring_add(front_q, dq_pkg::CNT_W'(1));
			if (cmd.push_front || cmd.push_rear) count_q <= count_q + 1'b1;
			else if (cmd.pop_front || cmd.pop_rear) count_q <= count_m1;
			if (cmd.dump_start) idx_q <= dq_pkg::IDX_W'(1);
			else if (cmd.dump_step) idx_q <= idx_q + 1'b1;

			if (cmd.push_front || cmd.push_rear) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_OK;
				last_q     <= 1'b1;
				from_ram_q <= 1'b0;
			end else if (cmd.reject_full) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_FULL;
				last_q     <= 1'b1;
				from_ram_q <= 1'b0;
			end else if (cmd.reject_empty) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_EMPTY;
				last_q     <= 1'b1;
				from_ram_q <= 1'b0;
			end else if (cmd.pop_front || cmd.pop_rear) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_OK;
				last_q     <= 1'b1;
				from_ram_q <= 1'b1;
			end else if (cmd.dump_start) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_OK;
				last_q     <= sts.single;
				from_ram_q <= 1'b1;
			end else if (cmd.dump_step) begin
				valid_q    <= 1'b1;
				status_q   <= dq_pkg::STATUS_OK;
				last_q     <= sts.dump_last;
				from_ram_q <= 1'b1;
			end else begin
				valid_q    <= 1'b0;
				from_ram_q <= 1'b0;
			end
		end
	end

	assign valid     = valid_q;
	assign status    = status_q;
	assign last      = last_q;
	assign value_out = from_ram_q ? rdata : '0;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("fill count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_rear) |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the fill count");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_rear) |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not shrink the fill count");

	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		re |=> valid_q && from_ram_q && status_q == dq_pkg::STATUS_OK)
		else $error("store read without an ok result");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_rear) |-> !sts.full)
		else $error("push into a full queue");
`endif

endmodule

// ===== rtl/double_ended_queue.sv =====
// top level of the bounded double-ended queue
// A request is taken when start is high and busy is low. Push front, push
// rear, pop front and pop rear keep busy low, and the single result appears
// with valid high in the cycle after the request. A dump reads the held
// entries from the ring store, one read per entry; when more than one is held,
// busy is high from the cycle after the request until the final read. Its results stream
// with valid high on consecutive cycles, front to rear, last marking the final
// one. Each result is on the ports for exactly one cycle and cannot be held
// off, so the receiver must take it when valid is high. Unused kind codes give
// no result and change nothing. No clearing pass follows reset.
module double_ended_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [dq_pkg::KIND_W-1:0]          kind,
	input  logic signed [dq_pkg::WORD_W-1:0]   value_in,
	output logic                               valid,
	output logic signed [dq_pkg::WORD_W-1:0]   value_out,
	output logic [dq_pkg::STATUS_W-1:0]        status,
	output logic                               last
);

	dq_pkg::cmd_t cmd;
	dq_pkg::sts_t sts;

	dq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	dq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value_in (value_in),
		.sts      (sts),
		.valid    (valid),
		.value_out(value_out),
		.status   (status),
		.last     (last)
	);

endmodule
